FILE: hw/rtl/sm4_pkg.sv
package sm4_pkg;

  localparam int unsigned ROUND_COUNT = 32;
  localparam int unsigned RK_AW       = $clog2(ROUND_COUNT);

  // Register map (index = paddr[3])
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  // System parameter FK
  localparam logic [31:0] FK [4] = '{
    32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
  };

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  typedef struct packed {
    logic        mode;
    logic [63:0] data_high;
    logic [63:0] data_low;
  } sm4_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } sm4_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             key_load;
    logic             key_step;
    logic             blk_load;
    logic             round_step;
    logic             out_load;
    logic [RK_AW-1:0] cnt;
    logic [RK_AW-1:0] rk_raddr;
  } sm4_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } sm4_sts_t;

  // Non-linear byte substitution tau
  function automatic logic [31:0] sub_word(logic [31:0] a);
    return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
  endfunction

  // Linear transform L (data rounds)
  function automatic logic [31:0] lin_data(logic [31:0] b);
    return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]} ^
           {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
  endfunction

  // Linear transform L' (key schedule)
  function automatic logic [31:0] lin_key(logic [31:0] b);
    return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
  endfunction

  // CK word i: byte j = (4i + j) * 7 mod 256, MSB first
  function automatic logic [31:0] ck_word(logic [RK_AW-1:0] i);
    logic [7:0]  base;
    logic [7:0]  b;
    logic [31:0] w;
    base = 8'({i, 2'b00});
    w    = '0;
    for (int j = 0; j < 4; j++) begin
      b = 8'((base + 8'(j)) * 8'd7);
      w[31-8*j -: 8] = b;
    end
    return w;
  endfunction

endpackage

FILE: hw/rtl/sm4_block_cipher.sv
// SM4 block cipher, one 128-bit block per request, iterative core doing one
// round per clock through a single S-box shared with the key schedule. A block
// is taken when in_ready_o is high, runs 32 rounds and lands in the output
// register once that register is free; the next block is accepted the cycle
// after that, even while the previous result still waits on out_ready_i, so a
// new block is taken only once the last one is in the output register. mode = 1
// encrypts, mode = 0 decrypts. The key is written over APB at 0x0 (key_high) and
// 0x8 (key_low), paddr[3] selecting the register. After reset and after every
// key write the 32 round keys are rebuilt into a 32x32 RAM, one per cycle
// through the same S-box unit; no block is accepted during the rebuild. Write
// keys only while no block is in flight.
module sm4_block_cipher (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Data in
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sm4_pkg::sm4_in_t   in_data_i,
  // Data out
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sm4_pkg::sm4_out_t  out_data_o,
  // Configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  logic [63:0]        key_high_q;
  logic [63:0]        key_low_q;
  logic               key_wr;
  sm4_pkg::sm4_cmd_t  cmd;
  sm4_pkg::sm4_sts_t  sts;

  assign pready = 1'b1;
  assign key_wr = psel & penable & pwrite;

  // Key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (key_wr) begin
      if (paddr[3] == sm4_pkg::REG_KEY_HIGH) begin
        key_high_q <= pwdata;
      end else begin
        key_low_q <= pwdata;
      end
    end
  end

  // Register read back
  assign prdata = (paddr[3] == sm4_pkg::REG_KEY_HIGH) ? key_high_q : key_low_q;

  sm4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_wr_i   (key_wr),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_data_i.mode),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sm4_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_high_i  (key_high_q),
    .key_low_i   (key_low_q),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: hw/rtl/sm4_ram.sv
module sm4_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/sm4_ctrl.sv
module sm4_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                key_wr_i,
  input  logic                in_valid_i,
  input  logic                in_mode_i,
  output logic                in_ready_o,
  input  sm4_pkg::sm4_sts_t   sts_i,
  output sm4_pkg::sm4_cmd_t   cmd_o
);

  localparam logic [2:0] S_KINIT = 3'd0;
  localparam logic [2:0] S_KEY   = 3'd1;
  localparam logic [2:0] S_IDLE  = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [sm4_pkg::RK_AW-1:0] LastCnt = sm4_pkg::RK_AW'(sm4_pkg::ROUND_COUNT - 1);

  logic [2:0]                  state_q, state_d;
  logic [sm4_pkg::RK_AW-1:0]   cnt_q, cnt_d;
  logic                        enc_q, enc_d;
  logic [sm4_pkg::RK_AW-1:0]   rk_idx;
  logic                        enc_sel;
  logic                        accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  // Round key read address: prefetched for the following round, as the RAM read is registered
  assign rk_idx  = (state_q == S_ROUND) ? cnt_q + 1'b1 : '0;
  assign enc_sel = (state_q == S_ROUND) ? enc_q : in_mode_i;

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    enc_d          = enc_q;
    cmd_o          = '0;
    cmd_o.cnt      = cnt_q;
    cmd_o.rk_raddr = enc_sel ? rk_idx : ~rk_idx;
    case (state_q)
      S_KINIT: begin
        cmd_o.key_load = 1'b1;
        cnt_d          = '0;
        state_d        = S_KEY;
      end
      S_KEY: begin
        cmd_o.key_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.blk_load = 1'b1;
          enc_d          = in_mode_i;
          cnt_d          = '0;
          state_d        = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd_o.round_step = 1'b1;
        cnt_d            = cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_KINIT;
      end
    endcase
    // A key write restarts the expansion
    if (key_wr_i) begin
      state_d = S_KINIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_KINIT;
      cnt_q   <= '0;
      enc_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      enc_q   <= enc_d;
    end
  end

endmodule

FILE: hw/rtl/sm4_dp.sv
module sm4_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [63:0]         key_high_i,
  input  logic [63:0]         key_low_i,
  input  sm4_pkg::sm4_in_t    in_data_i,
  input  sm4_pkg::sm4_cmd_t   cmd_i,
  output sm4_pkg::sm4_sts_t   sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sm4_pkg::sm4_out_t   out_data_o
);

  logic [31:0] k_q [4];
  logic [31:0] x_q [4];
  logic [31:0] rk_rdata;
  logic [31:0] t_in;
  logic [31:0] t_sub;
  logic [31:0] rk_new;
  logic [31:0] x_new;
  logic        out_valid_q, out_valid_d;
  sm4_pkg::sm4_out_t out_q;

  // Shared S-box word: key schedule or cipher round
  assign t_in   = cmd_i.key_step
                ? (k_q[1] ^ k_q[2] ^ k_q[3] ^ sm4_pkg::ck_word(cmd_i.cnt))
                : (x_q[1] ^ x_q[2] ^ x_q[3] ^ rk_rdata);
  assign t_sub  = sm4_pkg::sub_word(t_in);
  assign rk_new = k_q[0] ^ sm4_pkg::lin_key(t_sub);
  assign x_new  = x_q[0] ^ sm4_pkg::lin_data(t_sub);

  // Round key store
  sm4_ram #(
    .Width (32),
    .Depth (sm4_pkg::ROUND_COUNT)
  ) u_rk_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.key_step),
    .waddr_i (cmd_i.cnt),
    .wdata_i (rk_new),
    .raddr_i (cmd_i.rk_raddr),
    .rdata_o (rk_rdata)
  );

  // Key schedule words
  always_ff @(posedge clk_i) begin
    if (cmd_i.key_load) begin
      k_q[0] <= key_high_i[63:32] ^ sm4_pkg::FK[0];
      k_q[1] <= key_high_i[31:0]  ^ sm4_pkg::FK[1];
      k_q[2] <= key_low_i[63:32]  ^ sm4_pkg::FK[2];
      k_q[3] <= key_low_i[31:0]   ^ sm4_pkg::FK[3];
    end else if (cmd_i.key_step) begin
      k_q[0] <= k_q[1];
      k_q[1] <= k_q[2];
      k_q[2] <= k_q[3];
      k_q[3] <= rk_new;
    end
  end

  // Cipher state words
  always_ff @(posedge clk_i) begin
    if (cmd_i.blk_load) begin
      x_q[0] <= in_data_i.data_high[63:32];
      x_q[1] <= in_data_i.data_high[31:0];
      x_q[2] <= in_data_i.data_low[63:32];
      x_q[3] <= in_data_i.data_low[31:0];
    end else if (cmd_i.round_step) begin
      x_q[0] <= x_q[1];
      x_q[1] <= x_q[2];
      x_q[2] <= x_q[3];
      x_q[3] <= x_new;
    end
  end

  // Output register, words reversed
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.result_high <= {x_q[3], x_q[2]};
      out_q.result_low  <= {x_q[1], x_q[0]};
    end
  end

  assign out_valid_d = cmd_i.out_load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.out_free = ~out_valid_q | out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

FILE: dv/sm4_tb_pkg.sv
`timescale 1ns / 100ps

package sm4_tb_pkg;

  localparam int ROUNDS = 32;

  localparam logic MODE_ENC = 1'b1;
  localparam logic MODE_DEC = 1'b0;

  // SM4 substitution table
  localparam logic [7:0] SUBST [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // FK system parameter, XORed into the key before expansion
  localparam logic [31:0] KEY_FK [4] = '{
    32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
  };

  function automatic logic [31:0] rotl(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] subst_word(logic [31:0] a);
    return {SUBST[a[31:24]], SUBST[a[23:16]], SUBST[a[15:8]], SUBST[a[7:0]]};
  endfunction

  // CK constant: byte j of word i is (4i + j) * 7 mod 256, MSB first
  function automatic logic [31:0] ck_const(int i);
    logic [31:0] w;
    w = '0;
    for (int j = 0; j < 4; j++) w = {w[23:0], 8'(((4 * i + j) * 7) & 255)};
    return w;
  endfunction

  // Holds the key, its round keys and the queue of blocks still owed by the core
  class sm4_cipher_board;
    logic [63:0]       key_high_q;
    logic [63:0]       key_low_q;
    logic [31:0]       round_keys [ROUNDS];
    sm4_pkg::sm4_out_t expected_blocks [$];
    int                n_errors  = 0;
    int                n_checked = 0;
    int                n_enc     = 0;
    int                n_dec     = 0;
    int                n_keys    = 0;

    function new();
      key_high_q = '0;
      key_low_q  = '0;
      expand_keys();
    endfunction

    // Key schedule: K = MK ^ FK, then rk[i] = K0 ^ T'(K1 ^ K2 ^ K3 ^ CK[i])
    function void expand_keys();
      logic [31:0] k [4];
      logic [31:0] t;
      k[0] = key_high_q[63:32] ^ KEY_FK[0];
      k[1] = key_high_q[31:0]  ^ KEY_FK[1];
      k[2] = key_low_q[63:32]  ^ KEY_FK[2];
      k[3] = key_low_q[31:0]   ^ KEY_FK[3];
      for (int i = 0; i < ROUNDS; i++) begin
        t = subst_word(k[1] ^ k[2] ^ k[3] ^ ck_const(i));
        round_keys[i] = k[0] ^ t ^ rotl(t, 13) ^ rotl(t, 23);
        k[0] = k[1];
        k[1] = k[2];
        k[2] = k[3];
        k[3] = round_keys[i];
      end
    endfunction

    function void set_key(logic idx, logic [63:0] value);
      if (idx == sm4_pkg::REG_KEY_HIGH) key_high_q = value;
      else key_low_q = value;
      n_keys++;
      expand_keys();
    endfunction

    // 32 rounds; decryption walks the round keys backwards, output words reversed
    function sm4_pkg::sm4_out_t cipher_block(sm4_pkg::sm4_in_t blk);
      logic [31:0]       x [4];
      logic [31:0]       t;
      sm4_pkg::sm4_out_t r;
      x[0] = blk.data_high[63:32];
      x[1] = blk.data_high[31:0];
      x[2] = blk.data_low[63:32];
      x[3] = blk.data_low[31:0];
      for (int i = 0; i < ROUNDS; i++) begin
        t = subst_word(x[1] ^ x[2] ^ x[3] ^
                       round_keys[(blk.mode == MODE_ENC) ? i : ROUNDS - 1 - i]);
        t = x[0] ^ t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
        x[0] = x[1];
        x[1] = x[2];
        x[2] = x[3];
        x[3] = t;
      end
      r.result_high = {x[3], x[2]};
      r.result_low  = {x[1], x[0]};
      return r;
    endfunction

    function void note_request(sm4_pkg::sm4_in_t blk);
      if (blk.mode == MODE_ENC) n_enc++;
      else n_dec++;
      expected_blocks.push_back(cipher_block(blk));
    endfunction

    function void check_result(sm4_pkg::sm4_out_t got);
      sm4_pkg::sm4_out_t want;
      if (expected_blocks.size() == 0) begin
        $error("result %h with no request outstanding", got);
        n_errors++;
        return;
      end
      want = expected_blocks.pop_front();
      n_checked++;
      if (got.result_high !== want.result_high) begin
        $error("result_high: expected %h, got %h", want.result_high, got.result_high);
        n_errors++;
      end
      if (got.result_low !== want.result_low) begin
        $error("result_low: expected %h, got %h", want.result_low, got.result_low);
        n_errors++;
      end
    endfunction
  endclass

endpackage

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import sm4_tb_pkg::*;
  import sm4_pkg::REG_KEY_HIGH;
  import sm4_pkg::REG_KEY_LOW;

  localparam int SETTLE      = 40;   // covers an in-flight block and a key rebuild
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 130;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_RARE, RX_PERIODIC} rx_style_e;

  logic              clk      = 1'b0;
  logic              rst_n    = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  sm4_pkg::sm4_in_t  in_data  = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  sm4_pkg::sm4_out_t out_data;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [3:0]        paddr   = '0;
  logic [63:0]       pwdata  = '0;
  logic [63:0]       prdata;
  logic              pready;

  logic              hold_go    = 1'b0;
  int                burst_left = 0;
  int                gap_max    = 0;
  rx_style_e         rx_style   = RX_ALWAYS;
  sm4_cipher_board   board      = new();

  sm4_block_cipher dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
  end

  // Receiver: back-pressure style changes every so often; one long hold-off on request
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        out_ready = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
        hold_go = 1'b0;
      end
      cyc++;
      if (cyc % 150 == 0) rx_style = rx_style_e'($urandom_range(0, 3));
      case (rx_style)
        RX_ALWAYS: out_ready = 1'b1;
        RX_COIN:   out_ready = ($urandom_range(0, 1) == 1);
        RX_RARE:   out_ready = ($urandom_range(0, 9) != 0);
        default:   out_ready = ((cyc % 64) < 20);
      endcase
    end
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("tb_top: timed out, %0d results still owed", board.expected_blocks.size());
    $display("tb_top: done, errors");
    $finish;
  end

  // Mostly random words, with the odd zero, all-ones or single-bit value
  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offer one request; valid stays up across a burst, drops for a random gap after it
  task automatic push(input logic m, input logic [63:0] hi, input logic [63:0] lo);
    sm4_pkg::sm4_in_t blk;
    blk.mode      = m;
    blk.data_high = hi;
    blk.data_low  = lo;
    in_valid = 1'b1;
    in_data  = blk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(blk);
    @(negedge clk);
    if (burst_left > 0 || gap_max == 0) begin
      if (burst_left > 0) burst_left--;
    end else begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, gap_max)) @(negedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic wait_idle();
    in_valid   = 1'b0;
    burst_left = 0;
    while (board.expected_blocks.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Setup then access phase; data sampled at the completing edge
  task automatic apb_access(input logic wr, input logic idx, input logic [63:0] wdata,
                            output logic [63:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 3'b000};
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic read_check(input logic idx, input logic [63:0] want);
    logic [63:0] rd;
    string       name;
    name = (idx == REG_KEY_HIGH) ? "key_high" : "key_low";
    apb_access(1'b0, idx, '0, rd);
    if (rd !== want) begin
      $error("%s: expected %h, got %h", name, want, rd);
      board.n_errors++;
    end
  endtask

  task automatic write_key(input logic idx, input logic [63:0] value);
    logic [63:0] rd;
    wait_idle();
    apb_access(1'b1, idx, value, rd);
    board.set_key(idx, value);
    read_check(idx, value);
  endtask

  initial begin
    logic [63:0]       hi;
    logic [63:0]       lo;
    sm4_pkg::sm4_in_t  blk;
    sm4_pkg::sm4_out_t ct;
    int                n;
    int                key_sel;
    bit                held;
    held = 1'b0;

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Reset key is all zero
    read_check(REG_KEY_HIGH, '0);
    read_check(REG_KEY_LOW, '0);
    push(MODE_ENC, '0, '0);
    push(MODE_ENC, '1, '1);
    push(MODE_DEC, '0, '0);
    push(MODE_DEC, '1, '1);

    // Standard test key: known vector both ways, plus MSB/LSB patterns
    write_key(REG_KEY_HIGH, 64'h0123456789abcdef);
    write_key(REG_KEY_LOW, 64'hfedcba9876543210);
    push(MODE_ENC, 64'h0123456789abcdef, 64'hfedcba9876543210);
    push(MODE_DEC, 64'h681edf34d206965e, 64'h86b3e94f536e4246);
    push(MODE_ENC, 64'h8000000000000000, 64'h0000000000000001);
    push(MODE_DEC, 64'h0000000000000001, 64'h8000000000000000);

    // Only the high half rewritten: the low half must carry over
    write_key(REG_KEY_HIGH, '1);
    push(MODE_ENC, 64'h0123456789abcdef, 64'hfedcba9876543210);
    push(MODE_DEC, '0, '0);

    // All-ones key
    write_key(REG_KEY_LOW, '1);
    push(MODE_ENC, '0, '0);
    push(MODE_ENC, '1, '1);
    push(MODE_DEC, '1, '1);
    push(MODE_DEC, 64'ha5a5a5a5a5a5a5a5, 64'h5a5a5a5a5a5a5a5a);

    // Back to the zero key
    write_key(REG_KEY_HIGH, '0);
    write_key(REG_KEY_LOW, '0);
    push(MODE_ENC, 64'h5a5a5a5a5a5a5a5a, 64'ha5a5a5a5a5a5a5a5);
    push(MODE_DEC, 64'h5a5a5a5a5a5a5a5a, 64'ha5a5a5a5a5a5a5a5);

    // Random phases, each under a fresh key setting and sender pacing
    for (int p = 0; p < PHASES; p++) begin
      key_sel = (p == 0) ? 0 : $urandom_range(0, 3);
      case (key_sel)
        0: begin
          write_key(REG_KEY_HIGH, {$urandom, $urandom});
          write_key(REG_KEY_LOW, {$urandom, $urandom});
        end
        1: write_key(REG_KEY_HIGH, pick_word());
        2: write_key(REG_KEY_LOW, pick_word());
        default: begin
          hi = ($urandom_range(0, 1) == 1) ? '1 : '0;
          write_key(REG_KEY_HIGH, hi);
          write_key(REG_KEY_LOW, hi);
        end
      endcase
      gap_max = (p == 0) ? 0 : $urandom_range(0, 3) * 8;

      n = 0;
      while (n < PHASE_ITEMS) begin
        // long output hold-off while requests keep coming
        if (p == 2 && n >= 30 && !held) begin
          hold_go = 1'b1;
          held    = 1'b1;
        end
        hi = pick_word();
        lo = pick_word();
        if ($urandom_range(0, 3) == 0) begin
          // encrypt, then decrypt the ciphertext straight back
          blk.mode      = MODE_ENC;
          blk.data_high = hi;
          blk.data_low  = lo;
          ct = board.cipher_block(blk);
          push(MODE_ENC, hi, lo);
          push(MODE_DEC, ct.result_high, ct.result_low);
          n += 2;
        end else begin
          push($urandom_range(0, 1) == 1, hi, lo);
          n++;
        end
      end
    end

    wait_idle();
    $display("tb_top: %0d blocks checked (%0d encrypt, %0d decrypt) across %0d key writes",
             board.n_checked, board.n_enc, board.n_dec, board.n_keys);
    $display("tb_top: included zero/all-ones keys, round trips and a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (board.n_errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/sm4_pkg.sv
hw/rtl/sm4_ram.sv
hw/rtl/sm4_ctrl.sv
hw/rtl/sm4_dp.sv
hw/rtl/sm4_block_cipher.sv
dv/sm4_tb_pkg.sv
dv/tb_top.sv
